>>> design/tbmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmm_pkg
// Shared widths, register indexes, reset values and types of the tilt
// balance motor mixer.
// ----------------------------------------------------------------------------
package tbmm_pkg;

  localparam int ANGLE_W    = 17;
  localparam int DRIVE_W    = 9;
  localparam int SPEED_W    = 8;
  localparam int THRESH_W   = 16;
  localparam int STEER_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALANCE_ENABLE = 3'd0,
    CFG_BALANCE_SPEED  = 3'd1,
    CFG_STEER_SPEED    = 3'd2,
    CFG_ACT_THRESH     = 3'd3,
    CFG_REL_THRESH     = 3'd4
  } cfg_idx_t;

  localparam logic                RST_BALANCE_ENABLE = 1'b1;
  localparam logic [SPEED_W-1:0]  RST_BALANCE_SPEED  = 8'd150;
  localparam logic [SPEED_W-1:0]  RST_STEER_SPEED    = 8'd150;
  localparam logic [THRESH_W-1:0] RST_ACT_THRESH     = 16'd1024;
  localparam logic [THRESH_W-1:0] RST_REL_THRESH     = 16'd384;

  localparam logic [STEER_W-1:0] STEER_RIGHT = 2'b01;
  localparam logic [STEER_W-1:0] STEER_LEFT  = 2'b11;

  typedef struct packed {
    logic                balance_enable;
    logic [SPEED_W-1:0]  balance_speed;
    logic [SPEED_W-1:0]  steer_speed;
    logic [THRESH_W-1:0] act_thresh;
    logic [THRESH_W-1:0] rel_thresh;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic positive;
  } axis_t;

endpackage
`default_nettype wire

>>> design/tbmm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmm_cfg
// Configuration register file, written by index, reset to default values.
// ----------------------------------------------------------------------------
module tbmm_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tbmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbmm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tbmm_pkg::cfg_t                          cfg
);

  tbmm_pkg::cfg_t cfg_r;
  tbmm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tbmm_pkg::CFG_BALANCE_ENABLE: cfg_nxt.balance_enable = cfg_wdata[0];
        tbmm_pkg::CFG_BALANCE_SPEED:
          cfg_nxt.balance_speed = cfg_wdata[tbmm_pkg::SPEED_W-1:0];
        tbmm_pkg::CFG_STEER_SPEED:
          cfg_nxt.steer_speed = cfg_wdata[tbmm_pkg::SPEED_W-1:0];
        tbmm_pkg::CFG_ACT_THRESH:
          cfg_nxt.act_thresh = cfg_wdata[tbmm_pkg::THRESH_W-1:0];
        tbmm_pkg::CFG_REL_THRESH:
          cfg_nxt.rel_thresh = cfg_wdata[tbmm_pkg::THRESH_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.balance_enable <= tbmm_pkg::RST_BALANCE_ENABLE;
      cfg_r.balance_speed  <= tbmm_pkg::RST_BALANCE_SPEED;
      cfg_r.steer_speed    <= tbmm_pkg::RST_STEER_SPEED;
      cfg_r.act_thresh     <= tbmm_pkg::RST_ACT_THRESH;
      cfg_r.rel_thresh     <= tbmm_pkg::RST_REL_THRESH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> design/tbmm_hyst.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmm_hyst
// One axis: magnitude, two-threshold hysteresis and direction of the term.
// ----------------------------------------------------------------------------
module tbmm_hyst (
  input  wire logic signed [tbmm_pkg::ANGLE_W-1:0]  angle,
  input  wire logic                                 flag,
  input  wire logic [tbmm_pkg::THRESH_W-1:0]        act_thresh,
  input  wire logic [tbmm_pkg::THRESH_W-1:0]        rel_thresh,
  output tbmm_pkg::axis_t                           axis
);

  logic [tbmm_pkg::ANGLE_W-1:0] mag;
  logic [tbmm_pkg::ANGLE_W-1:0] high_ext;
  logic [tbmm_pkg::ANGLE_W-1:0] low_ext;

  always_comb begin
    mag      = angle[tbmm_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;
    high_ext = {1'b0, act_thresh};
    low_ext  = {1'b0, rel_thresh};

    if (mag > high_ext) begin
      axis.active = 1'b1;
    end else if (mag < low_ext) begin
      axis.active = 1'b0;
    end else begin
      axis.active = flag;
    end
    axis.positive = !angle[tbmm_pkg::ANGLE_W-1] && (angle != '0);
  end

endmodule
`default_nettype wire

>>> design/tbmm_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbmm_mix
// Mix pitch and roll terms into four motor drives, each clamped to the
// balance speed.
// ----------------------------------------------------------------------------
module tbmm_mix (
  input  wire tbmm_pkg::axis_t                         pitch,
  input  wire tbmm_pkg::axis_t                         roll,
  input  wire logic [tbmm_pkg::SPEED_W-1:0]            speed,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]          drive_a,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]          drive_b,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]          drive_c,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]          drive_d
);

  localparam int SUM_W = tbmm_pkg::DRIVE_W + 1;

  logic signed [SUM_W-1:0] lim;
  logic signed [SUM_W-1:0] p;
  logic signed [SUM_W-1:0] r;

  function automatic logic signed [tbmm_pkg::DRIVE_W-1:0] clampv(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] l
  );
    logic signed [SUM_W-1:0] res;
    if (v > l) begin
      res = l;
    end else if (v < -l) begin
      res = -l;
    end else begin
      res = v;
    end
    return res[tbmm_pkg::DRIVE_W-1:0];
  endfunction

  always_comb begin
    lim = $signed({{(SUM_W-tbmm_pkg::SPEED_W){1'b0}}, speed});
    p   = '0;
    r   = '0;
    if (pitch.active) begin
      p = pitch.positive ? lim : -lim;
    end
    if (roll.active) begin
      r = roll.positive ? lim : -lim;
    end
    drive_a = clampv(p - r, lim);
    drive_b = clampv(p + r, lim);
    drive_c = clampv(-p - r, lim);
    drive_d = clampv(-p + r, lim);
  end

endmodule
`default_nettype wire

>>> design/tilt_balance_motor_mixer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_balance_motor_mixer_core
// Path: input register, then result register, which drives out_*.
// Throughput: one beat per cycle unless out_ready stalls; input register and
// result register decouple the two channels, so one more beat is taken while
// a result waits. Reset: synchronous active-low; clears both axis flags
// and all valids and loads the configuration defaults. No clearing pass.
// ----------------------------------------------------------------------------
module tilt_balance_motor_mixer_core (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [tbmm_pkg::ANGLE_W-1:0]       in_pitch_angle,
  input  wire logic signed [tbmm_pkg::ANGLE_W-1:0]       in_roll_angle,
  input  wire logic                                      in_stop_request,
  input  wire logic signed [tbmm_pkg::STEER_W-1:0]       in_steer_direction,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]            out_drive_a,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]            out_drive_b,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]            out_drive_c,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]            out_drive_d,
  output logic signed [tbmm_pkg::DRIVE_W-1:0]            out_steer_drive,
  output logic                                           out_stopped,
  input  wire logic                                      cfg_we,
  input  wire logic [tbmm_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [tbmm_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  tbmm_pkg::cfg_t cfg;

  logic                                    s1_valid_r;
  logic signed [tbmm_pkg::ANGLE_W-1:0]     s1_pitch_r;
  logic signed [tbmm_pkg::ANGLE_W-1:0]     s1_roll_r;
  logic                                    s1_stop_r;
  logic signed [tbmm_pkg::STEER_W-1:0]     s1_steer_r;

  logic pitch_flag_r;
  logic roll_flag_r;
  logic pitch_flag_nxt;
  logic roll_flag_nxt;

  logic                                    out_valid_r;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_a_r;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_b_r;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_c_r;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_d_r;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     steer_drive_r;
  logic                                    stopped_r;

  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_a_nxt;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_b_nxt;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_c_nxt;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     drive_d_nxt;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     steer_drive_nxt;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     steer_mag;

  logic signed [tbmm_pkg::DRIVE_W-1:0]     mix_a;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     mix_b;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     mix_c;
  logic signed [tbmm_pkg::DRIVE_W-1:0]     mix_d;

  tbmm_pkg::axis_t pitch_axis;
  tbmm_pkg::axis_t roll_axis;

  logic halt;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  tbmm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tbmm_hyst u_hyst_pitch (
    .angle      (s1_pitch_r),
    .flag       (pitch_flag_r),
    .act_thresh (cfg.act_thresh),
    .rel_thresh (cfg.rel_thresh),
    .axis       (pitch_axis)
  );

  tbmm_hyst u_hyst_roll (
    .angle      (s1_roll_r),
    .flag       (roll_flag_r),
    .act_thresh (cfg.act_thresh),
    .rel_thresh (cfg.rel_thresh),
    .axis       (roll_axis)
  );

  tbmm_mix u_mix (
    .pitch   (pitch_axis),
    .roll    (roll_axis),
    .speed   (cfg.balance_speed),
    .drive_a (mix_a),
    .drive_b (mix_b),
    .drive_c (mix_c),
    .drive_d (mix_d)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign halt     = !cfg.balance_enable || s1_stop_r;

  always_comb begin
    steer_mag = $signed({1'b0, cfg.steer_speed});
    if (s1_steer_r == tbmm_pkg::STEER_RIGHT) begin
      steer_drive_nxt = steer_mag;
    end else if (s1_steer_r == tbmm_pkg::STEER_LEFT) begin
      steer_drive_nxt = -steer_mag;
    end else begin
      steer_drive_nxt = '0;
    end

    pitch_flag_nxt = pitch_axis.active;
    roll_flag_nxt  = roll_axis.active;
    drive_a_nxt    = mix_a;
    drive_b_nxt    = mix_b;
    drive_c_nxt    = mix_c;
    drive_d_nxt    = mix_d;
    if (halt) begin
      pitch_flag_nxt  = 1'b0;
      roll_flag_nxt   = 1'b0;
      drive_a_nxt     = '0;
      drive_b_nxt     = '0;
      drive_c_nxt     = '0;
      drive_d_nxt     = '0;
      steer_drive_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pitch_flag_r <= 1'b0;
      roll_flag_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        pitch_flag_r <= pitch_flag_nxt;
        roll_flag_r  <= roll_flag_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pitch_r <= in_pitch_angle;
      s1_roll_r  <= in_roll_angle;
      s1_stop_r  <= in_stop_request;
      s1_steer_r <= in_steer_direction;
    end
    if (s1_adv) begin
      drive_a_r     <= drive_a_nxt;
      drive_b_r     <= drive_b_nxt;
      drive_c_r     <= drive_c_nxt;
      drive_d_r     <= drive_d_nxt;
      steer_drive_r <= steer_drive_nxt;
      stopped_r     <= halt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_a     = drive_a_r;
  assign out_drive_b     = drive_b_r;
  assign out_drive_c     = drive_c_r;
  assign out_drive_d     = drive_d_r;
  assign out_steer_drive = steer_drive_r;
  assign out_stopped     = stopped_r;

endmodule
`default_nettype wire
